// ----- hdl/crsd_pkg.sv -----
`timescale 1ns / 1ps
// crsd_pkg: shared types and constants of the CAN request stream deframer.
// Used by every module of the block; depends on nothing.

package crsd_pkg;

    localparam int BYTE_W     = 8;
    localparam int ID_W       = 29;
    localparam int STD_ID_W   = 11;
    localparam int CNT_W      = 4;
    localparam int LANE_W     = 3;
    localparam int PAYLOAD_W  = 64;
    localparam int MAX_DATA   = 8;
    localparam int MIN_LENGTH = 4;
    localparam int MAX_LENGTH = 14;
    localparam int HDR_BYTES  = 2;
    localparam int STD_ID_BYTES = 2;
    localparam int EXT_ID_BYTES = 4;
    localparam logic [BYTE_W-1:0] TYPE_BAD_MASK = 8'hF9;

    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_START,
        OP_ID,
        OP_DATA,
        OP_ERROR
    } t_op;

    // One decoded step for the back end.
    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [LANE_W-1:0] lane;
        logic              extended;
        logic              remote;
        logic [CNT_W-1:0]  count;
    } t_cmd;

endpackage

// ----- hdl/crsd_front.sv -----
`timescale 1ns / 1ps
// crsd_front: byte classifier. Tracks record framing and turns each type,
// identifier and data byte, or error, into a back-end command. Depends on crsd_pkg.

module crsd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [crsd_pkg::BYTE_W-1:0]  i_data_byte,
    output logic                         o_cmd_valid,
    output crsd_pkg::t_cmd               o_cmd
);

    typedef enum logic [1:0] {
        PH_LENGTH,
        PH_TYPE,
        PH_BODY
    } t_phase;

    t_phase                         r_phase, n_phase;
    logic [crsd_pkg::CNT_W-1:0]     r_bytes_left, n_bytes_left;
    logic [crsd_pkg::CNT_W-1:0]     r_data_count, n_data_count;
    logic                           r_halted, n_halted;

    logic [crsd_pkg::CNT_W-1:0]     id_bytes;
    logic [crsd_pkg::CNT_W-1:0]     diff;
    logic [crsd_pkg::CNT_W-1:0]     lane_full;
    logic                           type_err;

    always_comb begin
        id_bytes  = i_data_byte[2] ? crsd_pkg::CNT_W'(crsd_pkg::EXT_ID_BYTES)
                                   : crsd_pkg::CNT_W'(crsd_pkg::STD_ID_BYTES);
        diff      = r_bytes_left - id_bytes;
        lane_full = r_data_count - r_bytes_left;
        type_err  = ((i_data_byte & crsd_pkg::TYPE_BAD_MASK) != '0)
                 || (r_bytes_left < id_bytes)
                 || (diff > crsd_pkg::CNT_W'(crsd_pkg::MAX_DATA))
                 || (i_data_byte[1] && (diff != '0));
    end

    always_comb begin
        n_phase        = r_phase;
        n_bytes_left   = r_bytes_left;
        n_data_count   = r_data_count;
        n_halted       = r_halted;
        o_cmd_valid    = 1'b0;
        o_cmd.op       = crsd_pkg::OP_ERROR;
        o_cmd.data     = i_data_byte;
        o_cmd.last     = (r_bytes_left == crsd_pkg::CNT_W'(1));
        o_cmd.lane     = lane_full[crsd_pkg::LANE_W-1:0];
        o_cmd.extended = i_data_byte[2];
        o_cmd.remote   = i_data_byte[1];
        o_cmd.count    = diff;
        if (i_accept && !r_halted) begin
            unique case (r_phase)
                PH_TYPE: begin
                    o_cmd_valid = 1'b1;
                    if (type_err) begin
                        o_cmd.op = crsd_pkg::OP_ERROR;
                        n_halted = 1'b1;
                        n_phase  = PH_LENGTH;
                    end else begin
                        o_cmd.op     = crsd_pkg::OP_START;
                        n_data_count = diff;
                        n_phase      = PH_BODY;
                    end
                end
                PH_BODY: begin
                    o_cmd_valid  = 1'b1;
                    o_cmd.op     = (r_bytes_left > r_data_count) ? crsd_pkg::OP_ID
                                                                 : crsd_pkg::OP_DATA;
                    n_bytes_left = r_bytes_left - crsd_pkg::CNT_W'(1);
                    if (r_bytes_left == crsd_pkg::CNT_W'(1)) begin
                        n_phase = PH_LENGTH;
                    end
                end
                default: begin
                    if ((i_data_byte < crsd_pkg::BYTE_W'(crsd_pkg::MIN_LENGTH))
                        || (i_data_byte > crsd_pkg::BYTE_W'(crsd_pkg::MAX_LENGTH))) begin
                        o_cmd_valid = 1'b1;
                        o_cmd.op    = crsd_pkg::OP_ERROR;
                        n_halted    = 1'b1;
                        n_phase     = PH_LENGTH;
                    end else begin
                        n_bytes_left = crsd_pkg::CNT_W'(i_data_byte
                                       - crsd_pkg::BYTE_W'(crsd_pkg::HDR_BYTES));
                        n_phase      = PH_TYPE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LENGTH;
            r_bytes_left <= '0;
            r_data_count <= '0;
            r_halted     <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_data_count <= n_data_count;
            r_halted     <= n_halted;
        end
    end

    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_valid && o_cmd.op == crsd_pkg::OP_ERROR) |=> r_halted)
        else $error("error command without halt");

    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted && !o_cmd_valid)
        else $error("halted stream produced a command");

    a_body_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_bytes_left != '0))
        else $error("body phase with no bytes left");

endmodule

// ----- hdl/crsd_cmd_fifo.sv -----
`timescale 1ns / 1ps
// crsd_cmd_fifo: short command queue between classifier and assembler.
// Depends on crsd_pkg.

module crsd_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  crsd_pkg::t_cmd  i_wr_cmd,
    output logic            o_full,
    input  logic            i_rd,
    output logic            o_valid,
    output crsd_pkg::t_cmd  o_rd_cmd
);

    crsd_pkg::t_cmd                  r_mem [crsd_pkg::CQ_DEPTH];
    logic [crsd_pkg::CQ_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [crsd_pkg::CQ_CNT_W-1:0]   r_count;
    logic                            wr_ok, rd_ok;

    assign o_full   = (r_count == crsd_pkg::CQ_CNT_W'(crsd_pkg::CQ_DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_rd_cmd = r_mem[r_rd_ptr];
    assign wr_ok    = i_wr && !o_full;
    assign rd_ok    = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_ok) begin
                r_wr_ptr <= r_wr_ptr + crsd_pkg::CQ_PTR_W'(1);
            end
            if (rd_ok) begin
                r_rd_ptr <= r_rd_ptr + crsd_pkg::CQ_PTR_W'(1);
            end
            r_count <= r_count + crsd_pkg::CQ_CNT_W'(wr_ok) - crsd_pkg::CQ_CNT_W'(rd_ok);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= crsd_pkg::CQ_CNT_W'(crsd_pkg::CQ_DEPTH))
        else $error("queue count overflow");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || o_full) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers out of step");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_ok && !rd_ok) |=> (r_count == $past(r_count) + crsd_pkg::CQ_CNT_W'(1)))
        else $error("queue count missed a write");

endmodule

// ----- hdl/crsd_back.sv -----
`timescale 1ns / 1ps
// crsd_back: frame assembler. Gathers identifier and data bytes from the
// command queue and holds the finished result item. Depends on crsd_pkg.

module crsd_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_valid,
    input  crsd_pkg::t_cmd                    i_cmd,
    output logic                              o_cmd_take,
    output logic                              o_out_valid,
    input  logic                              i_out_take,
    output logic                              o_status,
    output logic                              o_extended_id,
    output logic                              o_remote_request,
    output logic [crsd_pkg::ID_W-1:0]         o_identifier,
    output logic [crsd_pkg::CNT_W-1:0]        o_data_length,
    output logic [crsd_pkg::PAYLOAD_W-1:0]    o_payload
);

    logic                              r_out_valid;
    logic                              r_status;
    logic                              r_extended_id;
    logic                              r_remote_request;
    logic [crsd_pkg::ID_W-1:0]         r_identifier;
    logic [crsd_pkg::CNT_W-1:0]        r_data_length;
    logic [crsd_pkg::PAYLOAD_W-1:0]    r_payload;

    logic                              r_ext, r_rtr;
    logic [crsd_pkg::CNT_W-1:0]        r_count;
    logic [crsd_pkg::ID_W-1:0]         r_id, n_id;
    logic [crsd_pkg::PAYLOAD_W-1:0]    r_data, n_data;

    logic produces, slot_free, pop_ok;

    assign pop_ok     = i_out_take && r_out_valid;
    assign slot_free  = !r_out_valid || i_out_take;
    assign produces   = (i_cmd.op == crsd_pkg::OP_ERROR)
                     || (((i_cmd.op == crsd_pkg::OP_ID) || (i_cmd.op == crsd_pkg::OP_DATA))
                         && i_cmd.last);
    assign o_cmd_take = i_cmd_valid && (!produces || slot_free);

    always_comb begin
        n_id   = r_id;
        n_data = r_data;
        if (i_cmd.op == crsd_pkg::OP_ID) begin
            n_id = {r_id[crsd_pkg::ID_W-crsd_pkg::BYTE_W-1:0], i_cmd.data};
        end
        if (i_cmd.op == crsd_pkg::OP_DATA) begin
            n_data[i_cmd.lane*crsd_pkg::BYTE_W +: crsd_pkg::BYTE_W] = i_cmd.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            unique case (i_cmd.op)
                crsd_pkg::OP_START: begin
                    r_ext   <= i_cmd.extended;
                    r_rtr   <= i_cmd.remote;
                    r_count <= i_cmd.count;
                    r_id    <= '0;
                    r_data  <= '0;
                end
                crsd_pkg::OP_ID:   r_id   <= n_id;
                crsd_pkg::OP_DATA: r_data <= n_data;
                crsd_pkg::OP_ERROR: begin
                end
            endcase
        end
        if (o_cmd_take && produces) begin
            if (i_cmd.op == crsd_pkg::OP_ERROR) begin
                r_status         <= 1'b1;
                r_extended_id    <= 1'b0;
                r_remote_request <= 1'b0;
                r_identifier     <= '0;
                r_data_length    <= '0;
                r_payload        <= '0;
            end else begin
                r_status         <= 1'b0;
                r_extended_id    <= r_ext;
                r_remote_request <= r_rtr;
                r_identifier     <= r_ext ? n_id
                                          : {{(crsd_pkg::ID_W-crsd_pkg::STD_ID_W){1'b0}},
                                             n_id[crsd_pkg::STD_ID_W-1:0]};
                r_data_length    <= r_count;
                r_payload        <= n_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd_take && produces) begin
            r_out_valid <= 1'b1;
        end else if (pop_ok) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_extended_id    = r_extended_id;
    assign o_remote_request = r_remote_request;
    assign o_identifier     = r_identifier;
    assign o_data_length    = r_data_length;
    assign o_payload        = r_payload;

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status) |-> (r_payload == '0 && r_identifier == '0
                                       && r_data_length == '0 && !r_extended_id
                                       && !r_remote_request))
        else $error("error item carries frame fields");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_take) |-> !(o_cmd_take && produces))
        else $error("result overwritten before taken");

    a_length_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_status) |->
            (r_data_length <= crsd_pkg::CNT_W'(crsd_pkg::MAX_DATA)))
        else $error("frame data length out of range");

endmodule

// ----- hdl/can_request_stream_deframer_unit.sv -----
`timescale 1ns / 1ps
// can_request_stream_deframer_unit: top level of the CAN request deframer.
// Depends on crsd_pkg, crsd_front, crsd_cmd_fifo and crsd_back.

// One byte of the host request stream is accepted every clock cycle while
// full is low. The classifier decides framing and errors in the cycle the
// byte is accepted and writes a command for every type, identifier and data
// byte into a four-entry queue; the assembler consumes one command per cycle
// unless an unpopped result holds it, and loads a one-entry result register,
// so the result of a frame is registered there once the command of its last
// byte is taken, which waits while an unpopped result holds the assembler.
// Bytes stall only when the queue fills because results are not being
// popped. The first protocol error yields one item with status 1 and zeroed
// fields; afterwards bytes are accepted and dropped until reset.

module can_request_stream_deframer_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [crsd_pkg::BYTE_W-1:0]       i_data_byte,
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_status,
    output logic                              o_extended_id,
    output logic                              o_remote_request,
    output logic [crsd_pkg::ID_W-1:0]         o_identifier,
    output logic [crsd_pkg::CNT_W-1:0]        o_data_length,
    output logic [crsd_pkg::PAYLOAD_W-1:0]    o_payload
);

    logic           q_full, q_valid, q_take;
    logic           f_cmd_valid;
    crsd_pkg::t_cmd f_cmd, q_cmd;
    logic           out_valid;

    assign full  = q_full;
    assign empty = !out_valid;

    crsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (push && !q_full),
        .i_data_byte (i_data_byte),
        .o_cmd_valid (f_cmd_valid),
        .o_cmd       (f_cmd)
    );

    crsd_cmd_fifo u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (f_cmd_valid),
        .i_wr_cmd (f_cmd),
        .o_full   (q_full),
        .i_rd     (q_take),
        .o_valid  (q_valid),
        .o_rd_cmd (q_cmd)
    );

    crsd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (q_valid),
        .i_cmd            (q_cmd),
        .o_cmd_take       (q_take),
        .o_out_valid      (out_valid),
        .i_out_take       (pop),
        .o_status         (o_status),
        .o_extended_id    (o_extended_id),
        .o_remote_request (o_remote_request),
        .o_identifier     (o_identifier),
        .o_data_length    (o_data_length),
        .o_payload        (o_payload)
    );

endmodule

// ----- tb/can_frame_checker.sv -----
`timescale 1ns / 1ps
// can_frame_checker: watches the byte and frame channels of the deframer,
// predicts each frame result and compares it field by field.
// Depends on crsd_pkg.

module can_frame_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic                           i_full,
    input  logic [crsd_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                           i_empty,
    input  logic                           i_pop,
    input  logic                           i_status,
    input  logic                           i_extended_id,
    input  logic                           i_remote_request,
    input  logic [crsd_pkg::ID_W-1:0]      i_identifier,
    input  logic [crsd_pkg::CNT_W-1:0]     i_data_length,
    input  logic [crsd_pkg::PAYLOAD_W-1:0] i_payload,
    output int                             o_pending,
    output int                             o_mismatches
);

    typedef enum logic [1:0] {
        AWAIT_LENGTH,
        AWAIT_TYPE,
        IN_BODY
    } t_parse_phase;

    typedef struct packed {
        logic                           status;
        logic                           extended;
        logic                           remote;
        logic [crsd_pkg::ID_W-1:0]      identifier;
        logic [crsd_pkg::CNT_W-1:0]     data_length;
        logic [crsd_pkg::PAYLOAD_W-1:0] payload;
    } t_frame_result;

    t_parse_phase                   phase;
    logic [crsd_pkg::CNT_W-1:0]     left;
    logic [1:0]                     ftype;
    logic [crsd_pkg::ID_W-1:0]      id_acc;
    logic [crsd_pkg::PAYLOAD_W-1:0] data_acc;
    logic [crsd_pkg::CNT_W-1:0]     dcount;
    logic                           halted;

    t_frame_result expected_frames[$];
    int            mismatches = 0;

    assign o_mismatches = mismatches;

    task automatic flag_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t ns: frame %s mismatch, got %0h expected %0h",
                 $realtime, field, got, want);
        mismatches++;
    endtask

    // Advances the parser by one byte; returns 1 when a result is due.
    function automatic logic parse_byte(input logic [crsd_pkg::BYTE_W-1:0] b,
                                        output t_frame_result res);
        int                          idn;
        logic                        fault;
        logic [crsd_pkg::LANE_W-1:0] lane;
        fault = 1'b0;
        res = '0;
        if (halted)
            return 1'b0;
        case (phase)
            AWAIT_TYPE: begin
                idn = b[2] ? crsd_pkg::EXT_ID_BYTES : crsd_pkg::STD_ID_BYTES;
                if ((b & crsd_pkg::TYPE_BAD_MASK) != '0) begin
                    fault = 1'b1;
                end else if (int'(left) < idn || int'(left) - idn > crsd_pkg::MAX_DATA) begin
                    fault = 1'b1;
                end else if (b[1] && int'(left) != idn) begin
                    fault = 1'b1;
                end else begin
                    ftype = b[2:1];
                    dcount = crsd_pkg::CNT_W'(int'(left) - idn);
                    id_acc = '0;
                    data_acc = '0;
                    phase = IN_BODY;
                end
            end
            IN_BODY: begin
                if (left > dcount) begin
                    id_acc = crsd_pkg::ID_W'({id_acc, b});
                end else begin
                    lane = crsd_pkg::LANE_W'(dcount - left);
                    data_acc = data_acc
                             | (crsd_pkg::PAYLOAD_W'(b) << (crsd_pkg::BYTE_W * int'(lane)));
                end
                left = left - crsd_pkg::CNT_W'(1);
                if (left == '0) begin
                    phase = AWAIT_LENGTH;
                    res.extended = ftype[1];
                    res.remote = ftype[0];
                    res.identifier = ftype[1] ? id_acc
                                              : crsd_pkg::ID_W'(id_acc[crsd_pkg::STD_ID_W-1:0]);
                    res.data_length = dcount;
                    res.payload = data_acc;
                    return 1'b1;
                end
            end
            default: begin
                if (int'(b) < crsd_pkg::MIN_LENGTH || int'(b) > crsd_pkg::MAX_LENGTH) begin
                    fault = 1'b1;
                end else begin
                    left = crsd_pkg::CNT_W'(int'(b) - crsd_pkg::HDR_BYTES);
                    phase = AWAIT_TYPE;
                end
            end
        endcase
        if (fault) begin
            halted = 1'b1;
            phase = AWAIT_LENGTH;
            res.status = 1'b1;
        end
        return fault;
    endfunction

    always @(posedge i_clk) begin
        t_frame_result got;
        t_frame_result want;
        t_frame_result fresh;
        if (!i_rst_n) begin
            phase = AWAIT_LENGTH;
            left = '0;
            ftype = '0;
            id_acc = '0;
            data_acc = '0;
            dcount = '0;
            halted = 1'b0;
            expected_frames.delete();
        end else begin
            if (i_pop && !i_empty) begin
                got = {i_status, i_extended_id, i_remote_request, i_identifier,
                       i_data_length, i_payload};
                if (expected_frames.size() == 0) begin
                    flag_mismatch("unexpected", 64'(got.identifier), '0);
                end else begin
                    want = expected_frames.pop_front();
                    if (got.status !== want.status)
                        flag_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.extended !== want.extended)
                        flag_mismatch("extended_id", 64'(got.extended),
                                      64'(want.extended));
                    if (got.remote !== want.remote)
                        flag_mismatch("remote_request", 64'(got.remote),
                                      64'(want.remote));
                    if (got.identifier !== want.identifier)
                        flag_mismatch("identifier", 64'(got.identifier),
                                      64'(want.identifier));
                    if (got.data_length !== want.data_length)
                        flag_mismatch("data_length", 64'(got.data_length),
                                      64'(want.data_length));
                    if (got.payload !== want.payload)
                        flag_mismatch("payload", got.payload, want.payload);
                end
            end
            if (i_push && !i_full) begin
                if (parse_byte(i_data_byte, fresh))
                    expected_frames.push_back(fresh);
            end
        end
        o_pending <= expected_frames.size();
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// testbench: drives CAN request byte streams into the deframer and gives the verdict.
// Depends on crsd_pkg, can_request_stream_deframer_unit and can_frame_checker.

module testbench;

    localparam logic [crsd_pkg::BYTE_W-1:0] TYPE_STD     = 8'h00;
    localparam logic [crsd_pkg::BYTE_W-1:0] TYPE_STD_RTR = 8'h02;
    localparam logic [crsd_pkg::BYTE_W-1:0] TYPE_EXT     = 8'h04;
    localparam logic [crsd_pkg::BYTE_W-1:0] TYPE_EXT_RTR = 8'h06;
    localparam int HOLD_CYCLES = 200;
    localparam int TAIL_CYCLES = 16;
    localparam int PHASE_BYTES = 110;

    typedef enum int {
        BRK_LEN_LOW,
        BRK_LEN_HIGH,
        BRK_TYPE_BITS,
        BRK_STD_OVERSIZE,
        BRK_EXT_SHORT,
        BRK_REMOTE_DATA
    } t_breakage;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           push;
    logic                           full;
    logic [crsd_pkg::BYTE_W-1:0]    data_byte;
    logic                           empty;
    logic                           pop;
    logic                           status;
    logic                           extended_id;
    logic                           remote_request;
    logic [crsd_pkg::ID_W-1:0]      identifier;
    logic [crsd_pkg::CNT_W-1:0]     data_length;
    logic [crsd_pkg::PAYLOAD_W-1:0] payload;

    int pending;
    int mismatches;
    int stall_pct = 0;
    int hold_requests = 0;
    int idle_pct = 0;
    int bytes_sent = 0;

    can_request_stream_deframer_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_data_byte      (data_byte),
        .empty            (empty),
        .pop              (pop),
        .o_status         (status),
        .o_extended_id    (extended_id),
        .o_remote_request (remote_request),
        .o_identifier     (identifier),
        .o_data_length    (data_length),
        .o_payload        (payload)
    );

    can_frame_checker frame_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_full           (full),
        .i_data_byte      (data_byte),
        .i_empty          (empty),
        .i_pop            (pop),
        .i_status         (status),
        .i_extended_id    (extended_id),
        .i_remote_request (remote_request),
        .i_identifier     (identifier),
        .i_data_length    (data_length),
        .i_payload        (payload),
        .o_pending        (pending),
        .o_mismatches     (mismatches)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Frame receiver: random stalls, plus a long hold-off on request.
    initial begin
        int hold_left;
        int holds_served;
        hold_left = 0;
        holds_served = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
                pop <= 1'b0;
            end else begin
                pop <= (int'($urandom_range(99)) >= stall_pct);
            end
        end
    end

    task automatic send_byte(input logic [crsd_pkg::BYTE_W-1:0] b);
        while (int'($urandom_range(99)) < idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        data_byte <= b;
        do @(posedge i_clk); while (full);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic ext, input logic rtr, input int dlen,
                              input logic [31:0] raw_id, input logic [63:0] data);
        int idn;
        idn = ext ? crsd_pkg::EXT_ID_BYTES : crsd_pkg::STD_ID_BYTES;
        send_byte(crsd_pkg::BYTE_W'(crsd_pkg::HDR_BYTES + idn + dlen));
        send_byte(ext ? (rtr ? TYPE_EXT_RTR : TYPE_EXT) : (rtr ? TYPE_STD_RTR : TYPE_STD));
        for (int i = idn - 1; i >= 0; i--)
            send_byte(raw_id[8*i +: 8]);
        for (int i = 0; i < dlen; i++)
            send_byte(data[8*i +: 8]);
    endtask

    task automatic random_frame();
        logic ext;
        logic rtr;
        ext = 1'($urandom_range(1));
        rtr = 1'($urandom_range(1));
        send_frame(ext, rtr, rtr ? 0 : int'($urandom_range(crsd_pkg::MAX_DATA)), $urandom,
                   {$urandom, $urandom});
    endtask

    task automatic drain_results();
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic run_phase(input int sender_pct, input int receiver_pct,
                             input int n_bytes);
        int target;
        target = bytes_sent + n_bytes;
        idle_pct = sender_pct;
        stall_pct <= receiver_pct;
        while (bytes_sent < target)
            random_frame();
        drain_results();
    endtask

    // Any protocol error halts the block for good, so exactly one is sent, last.
    task automatic send_breakage();
        t_breakage                   brk;
        logic [crsd_pkg::BYTE_W-1:0] t;
        brk = t_breakage'($urandom_range(BRK_REMOTE_DATA));
        case (brk)
            BRK_LEN_LOW:
                send_byte(crsd_pkg::BYTE_W'($urandom_range(crsd_pkg::MIN_LENGTH - 1)));
            BRK_LEN_HIGH:
                send_byte(crsd_pkg::BYTE_W'($urandom_range(255, crsd_pkg::MAX_LENGTH + 1)));
            BRK_TYPE_BITS: begin
                send_byte(crsd_pkg::BYTE_W'($urandom_range(crsd_pkg::MAX_LENGTH,
                                                           crsd_pkg::MIN_LENGTH)));
                do t = crsd_pkg::BYTE_W'($urandom_range(255));
                while ((t & crsd_pkg::TYPE_BAD_MASK) == '0);
                send_byte(t);
            end
            BRK_STD_OVERSIZE: begin
                send_byte(crsd_pkg::BYTE_W'($urandom_range(crsd_pkg::MAX_LENGTH,
                                                           crsd_pkg::MAX_LENGTH - 1)));
                send_byte($urandom_range(1) ? TYPE_STD_RTR : TYPE_STD);
            end
            BRK_EXT_SHORT: begin
                send_byte(crsd_pkg::BYTE_W'($urandom_range(crsd_pkg::MIN_LENGTH + 1,
                                                           crsd_pkg::MIN_LENGTH)));
                send_byte($urandom_range(1) ? TYPE_EXT_RTR : TYPE_EXT);
            end
            default: begin
                if ($urandom_range(1)) begin
                    send_byte(crsd_pkg::BYTE_W'($urandom_range(12, 5)));
                    send_byte(TYPE_STD_RTR);
                end else begin
                    send_byte(crsd_pkg::BYTE_W'($urandom_range(crsd_pkg::MAX_LENGTH, 7)));
                    send_byte(TYPE_EXT_RTR);
                end
            end
        endcase
    endtask

    initial begin
        i_rst_n <= 1'b0;
        push <= 1'b0;
        data_byte <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // standard remote with over-wide id, longest extended frame, one data byte
        send_frame(1'b0, 1'b1, 0, 32'hFFFF_FFFF, '0);
        send_frame(1'b1, 1'b0, crsd_pkg::MAX_DATA, 32'hFFFF_FFFF, 64'h8877_6655_4433_2211);
        send_frame(1'b0, 1'b0, 1, 32'h0000_0000, 64'hFF);
        drain_results();

        run_phase(0, 0, PHASE_BYTES);
        run_phase(86, 0, PHASE_BYTES);
        run_phase(0, 86, PHASE_BYTES);
        run_phase(19, 19, PHASE_BYTES);

        // receiver held off while bytes keep coming, so the input stalls
        idle_pct = 0;
        stall_pct <= 0;
        hold_requests <= hold_requests + 1;
        begin
            int target;
            target = bytes_sent + 100;
            while (bytes_sent < target)
                random_frame();
        end
        drain_results();

        // protocol error, then bytes that must all be dropped
        idle_pct = 19;
        send_breakage();
        repeat (40)
            send_byte(crsd_pkg::BYTE_W'($urandom_range(255)));
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/crsd_pkg.sv
hdl/crsd_front.sv
hdl/crsd_cmd_fifo.sv
hdl/crsd_back.sv
hdl/can_request_stream_deframer_unit.sv
tb/can_frame_checker.sv
tb/testbench.sv
